@@ src/sobb_pkg.sv @@
// Shared widths, register indexes and reset values for the segment/box overlap test.
package sobb_pkg;

    // Coordinate and axis formats
    localparam int COORD_W   = 20;
    localparam int AXIS_FRAC = 14;
    localparam int AXIS_W    = AXIS_FRAC + 2;
    localparam int CFG_W     = 3 * COORD_W;
    localparam int IDX_W     = 3;

    // Doubled midpoint and doubled half-vector
    localparam int M2_W = COORD_W + 2;
    localparam int D2_W = COORD_W + 1;

    // Rotation products and their sums
    localparam int PM_W = AXIS_W + M2_W;
    localparam int PD_W = AXIS_W + D2_W;
    localparam int MR_W = PM_W + 2;
    localparam int DR_W = PD_W + 2;

    // Half extents carry the doubling and the axis fraction
    localparam int EXT_SH = AXIS_FRAC + 1;

    // Cross-axis products are built from split halves
    localparam int SPLIT  = COORD_W;
    localparam int PP_W   = 2 * SPLIT + 2;
    localparam int RP_W   = 2 * SPLIT;
    localparam int PROD_W = MR_W + DR_W;
    localparam int LHS_W  = PROD_W + 1;

    localparam int PIPE_DEPTH = 7;

    // Identity box axes after reset
    localparam logic [3*AXIS_W-1:0] AXIS_ROW0_RST = (3*AXIS_W)'(1) << AXIS_FRAC;
    localparam logic [3*AXIS_W-1:0] AXIS_ROW1_RST = AXIS_ROW0_RST << AXIS_W;
    localparam logic [3*AXIS_W-1:0] AXIS_ROW2_RST = AXIS_ROW0_RST << (2 * AXIS_W);

    typedef enum logic [IDX_W-1:0] {
        REG_CENTER = 3'd0,
        REG_EXTENT = 3'd1,
        REG_AXIS0  = 3'd2,
        REG_AXIS1  = 3'd3,
        REG_AXIS2  = 3'd4
    } cfg_reg_t;

    // Stage enables handed to each cross-axis unit
    typedef struct packed {
        logic s4;
        logic s5;
        logic s6;
        logic s7;
    } cross_en_t;

endpackage

@@ src/sobb_cross_axis.sv @@
// One edge cross-axis separating test, pipelined over four stages.
module sobb_cross_axis (
    input  logic                             clk,
    input  sobb_pkg::cross_en_t              en,
    input  logic signed [sobb_pkg::MR_W-1:0] m_a,
    input  logic signed [sobb_pkg::MR_W-1:0] m_b,
    input  logic signed [sobb_pkg::DR_W-1:0] d_a,
    input  logic signed [sobb_pkg::DR_W-1:0] d_b,
    input  logic [sobb_pkg::COORD_W-1:0]     e_a,
    input  logic [sobb_pkg::COORD_W-1:0]     e_b,
    output logic                             sep
);
    import sobb_pkg::*;

    // Tests |m_a*d_b - m_b*d_a| > (e_a*|d_b| + e_b*|d_a|) << EXT_SH

    logic signed [PP_W-1:0]   pp_reg   [2][4];
    logic signed [PP_W-1:0]   pp_next  [2][4];
    logic [DR_W-1:0]          dmag_a_reg, dmag_b_reg, dmag_a_next, dmag_b_next;
    logic signed [PROD_W-1:0] prod_reg [2];
    logic signed [PROD_W-1:0] prod_next[2];
    logic [RP_W-1:0]          rp_reg   [2][2];
    logic [RP_W-1:0]          rp_next  [2][2];
    logic signed [LHS_W-1:0]  lhs_reg, lhs_next;
    logic [LHS_W-1:0]         rhs_reg, rhs_next;
    logic                     sep_reg, sep_next;

    // Stage 4: split partial products, magnitudes of the half-vectors
    always_comb
    begin
        logic signed [MR_W-1:0]       m;
        logic signed [DR_W-1:0]       d;
        logic [SPLIT-1:0]             ml;
        logic [SPLIT-1:0]             dl;
        logic signed [MR_W-SPLIT-1:0] mh;
        logic signed [DR_W-SPLIT-1:0] dh;
        for (int p = 0; p < 2; p++)
        begin
            m  = (p == 0) ? m_a : m_b;
            d  = (p == 0) ? d_b : d_a;
            ml = m[SPLIT-1:0];
            mh = m[MR_W-1:SPLIT];
            dl = d[SPLIT-1:0];
            dh = d[DR_W-1:SPLIT];
            pp_next[p][0] = PP_W'($signed({1'b0, ml})) * PP_W'($signed({1'b0, dl}));
            pp_next[p][1] = PP_W'($signed({1'b0, ml})) * PP_W'(dh);
            pp_next[p][2] = PP_W'(mh) * PP_W'($signed({1'b0, dl}));
            pp_next[p][3] = PP_W'(mh) * PP_W'(dh);
        end
        dmag_a_next = d_a[DR_W-1] ? DR_W'(-d_a) : DR_W'(d_a);
        dmag_b_next = d_b[DR_W-1] ? DR_W'(-d_b) : DR_W'(d_b);
    end

    // Stage 5: full cross products, extent partial products
    always_comb
    begin
        logic signed [PROD_W-1:0] x0, x1, x2, x3;
        for (int p = 0; p < 2; p++)
        begin
            x0 = PROD_W'(pp_reg[p][0]);
            x1 = PROD_W'(pp_reg[p][1]);
            x2 = PROD_W'(pp_reg[p][2]);
            x3 = PROD_W'(pp_reg[p][3]);
            prod_next[p] = (x3 <<< (2 * SPLIT)) + ((x2 + x1) <<< SPLIT) + x0;
        end
        rp_next[0][0] = RP_W'(e_a) * RP_W'(dmag_b_reg[SPLIT-1:0]);
        rp_next[0][1] = RP_W'(e_a) * RP_W'(dmag_b_reg[DR_W-1:SPLIT]);
        rp_next[1][0] = RP_W'(e_b) * RP_W'(dmag_a_reg[SPLIT-1:0]);
        rp_next[1][1] = RP_W'(e_b) * RP_W'(dmag_a_reg[DR_W-1:SPLIT]);
    end

    // Stage 6: difference of products, summed and scaled extent term
    always_comb
    begin
        logic signed [LHS_W-1:0] pa, pb;
        logic [LHS_W-1:0]        t0, t1;
        pa       = LHS_W'(prod_reg[0]);
        pb       = LHS_W'(prod_reg[1]);
        lhs_next = pa - pb;
        t0       = (LHS_W'(rp_reg[0][1]) << SPLIT) + LHS_W'(rp_reg[0][0]);
        t1       = (LHS_W'(rp_reg[1][1]) << SPLIT) + LHS_W'(rp_reg[1][0]);
        rhs_next = (t0 + t1) << EXT_SH;
    end

    // Stage 7: magnitude compare, equality does not separate
    always_comb
    begin
        logic [LHS_W-1:0] lhs_mag;
        lhs_mag  = lhs_reg[LHS_W-1] ? LHS_W'(-lhs_reg) : LHS_W'(lhs_reg);
        sep_next = lhs_mag > rhs_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en.s4)
        begin
            pp_reg     <= pp_next;
            dmag_a_reg <= dmag_a_next;
            dmag_b_reg <= dmag_b_next;
        end
        if (en.s5)
        begin
            prod_reg <= prod_next;
            rp_reg   <= rp_next;
        end
        if (en.s6)
        begin
            lhs_reg <= lhs_next;
            rhs_reg <= rhs_next;
        end
        if (en.s7)
        begin
            sep_reg <= sep_next;
        end
    end

    assign sep = sep_reg;

endmodule

@@ src/segment_obb_overlap_test.sv @@
// Top level: segment versus oriented box overlap test, seven-stage pipeline.
//
//  channel | signals                                   | dir | accepted when
//  --------+-------------------------------------------+-----+------------------------
//  in      | in_valid, in_ready, start_x..z, end_x..z  | in  | in_valid & in_ready
//  out     | out_valid, out_ready, hit                 | out | out_valid & out_ready
//  cfg     | cfg_wr_en, cfg_index, cfg_data            | in  | cfg_wr_en
//
//  One item per cycle while the output is not stalled; an accepted item passes stages 1 to 7 to hit.
//  Latency is set by the cross-axis products, split into halves over stages 4 to 6.
//  Reset clears all stage valid bits and loads center 0, extents 0, identity axes.
//  Each stage holds while the one after it is full and stalled; empty stages keep
//  filling, so up to seven items sit in flight behind a stalled output.
module segment_obb_overlap_test (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic signed [sobb_pkg::COORD_W-1:0] start_x,
    input  logic signed [sobb_pkg::COORD_W-1:0] start_y,
    input  logic signed [sobb_pkg::COORD_W-1:0] start_z,
    input  logic signed [sobb_pkg::COORD_W-1:0] end_x,
    input  logic signed [sobb_pkg::COORD_W-1:0] end_y,
    input  logic signed [sobb_pkg::COORD_W-1:0] end_z,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic                                hit,
    input  logic                                cfg_wr_en,
    input  logic [sobb_pkg::IDX_W-1:0]          cfg_index,
    input  logic [sobb_pkg::CFG_W-1:0]          cfg_data
);
    import sobb_pkg::*;

    logic [CFG_W-1:0]    center_reg;
    logic [CFG_W-1:0]    extent_reg;
    logic [3*AXIS_W-1:0] axis_reg [3];

    logic [PIPE_DEPTH:1] v_reg;
    logic [PIPE_DEPTH:1] v_next;
    logic [PIPE_DEPTH:1] en;

    logic signed [M2_W-1:0] m2_reg [3];
    logic signed [M2_W-1:0] m2_next[3];
    logic signed [D2_W-1:0] d2_reg [3];
    logic signed [D2_W-1:0] d2_next[3];
    logic signed [PM_W-1:0] pm_reg [3][3];
    logic signed [PM_W-1:0] pm_next[3][3];
    logic signed [PD_W-1:0] pd_reg [3][3];
    logic signed [PD_W-1:0] pd_next[3][3];
    logic signed [MR_W-1:0] mr_reg [3];
    logic signed [MR_W-1:0] mr_next[3];
    logic signed [DR_W-1:0] dr_reg [3];
    logic signed [DR_W-1:0] dr_next[3];
    logic                   face4_reg, face4_next;
    logic                   face5_reg, face6_reg, face7_reg;
    logic [COORD_W-1:0]     ext [3];
    logic [2:0]             cross_sep;
    cross_en_t              cross_en;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_reg  <= '0;
            extent_reg  <= '0;
            axis_reg[0] <= AXIS_ROW0_RST;
            axis_reg[1] <= AXIS_ROW1_RST;
            axis_reg[2] <= AXIS_ROW2_RST;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_CENTER: center_reg  <= cfg_data;
                REG_EXTENT: extent_reg  <= cfg_data;
                REG_AXIS0:  axis_reg[0] <= cfg_data[3*AXIS_W-1:0];
                REG_AXIS1:  axis_reg[1] <= cfg_data[3*AXIS_W-1:0];
                REG_AXIS2:  axis_reg[2] <= cfg_data[3*AXIS_W-1:0];
                default:    ;
            endcase
        end
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            ext[i] = extent_reg[i*COORD_W +: COORD_W];
        end
    end

    // Stage enables: a stage moves when it is empty or the next one moves
    always_comb
    begin
        en[PIPE_DEPTH] = !v_reg[PIPE_DEPTH] || out_ready;
        for (int k = PIPE_DEPTH - 1; k >= 1; k--)
        begin
            en[k] = !v_reg[k] || en[k+1];
        end
    end

    assign in_ready = en[1];
    assign v_next   = {v_reg[PIPE_DEPTH-1:1], in_valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            for (int k = 1; k <= PIPE_DEPTH; k++)
            begin
                if (en[k])
                begin
                    v_reg[k] <= v_next[k];
                end
            end
        end
    end

    // Stage 1: doubled midpoint relative to center, doubled half-vector
    always_comb
    begin
        logic signed [COORD_W-1:0] s_pt [3];
        logic signed [COORD_W-1:0] e_pt [3];
        logic signed [M2_W-1:0]    s_m, e_m, c_m;
        logic signed [D2_W-1:0]    s_d, e_d;
        s_pt[0] = start_x;
        s_pt[1] = start_y;
        s_pt[2] = start_z;
        e_pt[0] = end_x;
        e_pt[1] = end_y;
        e_pt[2] = end_z;
        for (int i = 0; i < 3; i++)
        begin
            s_m = M2_W'(s_pt[i]);
            e_m = M2_W'(e_pt[i]);
            c_m = M2_W'($signed(center_reg[i*COORD_W +: COORD_W]));
            s_d = D2_W'(s_pt[i]);
            e_d = D2_W'(e_pt[i]);
            m2_next[i] = s_m + e_m - (c_m <<< 1);
            d2_next[i] = e_d - s_d;
        end
    end

    // Stage 2: axis-by-component products
    always_comb
    begin
        logic signed [AXIS_W-1:0] a;
        for (int i = 0; i < 3; i++)
        begin
            for (int k = 0; k < 3; k++)
            begin
                a = $signed(axis_reg[i][k*AXIS_W +: AXIS_W]);
                pm_next[i][k] = PM_W'(a) * PM_W'(m2_reg[k]);
                pd_next[i][k] = PD_W'(a) * PD_W'(d2_reg[k]);
            end
        end
    end

    // Stage 3: dot products into box space
    always_comb
    begin
        logic signed [MR_W-1:0] pm0, pm1, pm2;
        logic signed [DR_W-1:0] pd0, pd1, pd2;
        for (int i = 0; i < 3; i++)
        begin
            pm0 = MR_W'(pm_reg[i][0]);
            pm1 = MR_W'(pm_reg[i][1]);
            pm2 = MR_W'(pm_reg[i][2]);
            pd0 = DR_W'(pd_reg[i][0]);
            pd1 = DR_W'(pd_reg[i][1]);
            pd2 = DR_W'(pd_reg[i][2]);
            mr_next[i] = pm0 + pm1 + pm2;
            dr_next[i] = pd0 + pd1 + pd2;
        end
    end

    // Stage 4: face-axis tests, |mr| > (ext << EXT_SH) + |dr| on any axis separates
    always_comb
    begin
        logic [MR_W-1:0] mr_mag;
        logic [MR_W-1:0] lim;
        face4_next = 1'b0;
        for (int i = 0; i < 3; i++)
        begin
            mr_mag = mr_reg[i][MR_W-1] ? MR_W'(-mr_reg[i]) : MR_W'(mr_reg[i]);
            lim    = (MR_W'(ext[i]) << EXT_SH)
                   + (dr_reg[i][DR_W-1] ? MR_W'(-dr_reg[i]) : MR_W'(dr_reg[i]));
            if (mr_mag > lim)
            begin
                face4_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            m2_reg <= m2_next;
            d2_reg <= d2_next;
        end
        if (en[2])
        begin
            pm_reg <= pm_next;
            pd_reg <= pd_next;
        end
        if (en[3])
        begin
            mr_reg <= mr_next;
            dr_reg <= dr_next;
        end
        if (en[4])
        begin
            face4_reg <= face4_next;
        end
        if (en[5])
        begin
            face5_reg <= face4_reg;
        end
        if (en[6])
        begin
            face6_reg <= face5_reg;
        end
        if (en[7])
        begin
            face7_reg <= face6_reg;
        end
    end

    // Edge cross-axis tests, stages 4 to 7
    assign cross_en.s4 = en[4];
    assign cross_en.s5 = en[5];
    assign cross_en.s6 = en[6];
    assign cross_en.s7 = en[7];

    sobb_cross_axis u_cross_x (
        .clk (clk),
        .en  (cross_en),
        .m_a (mr_reg[1]),
        .m_b (mr_reg[2]),
        .d_a (dr_reg[1]),
        .d_b (dr_reg[2]),
        .e_a (ext[1]),
        .e_b (ext[2]),
        .sep (cross_sep[0])
    );

    sobb_cross_axis u_cross_y (
        .clk (clk),
        .en  (cross_en),
        .m_a (mr_reg[2]),
        .m_b (mr_reg[0]),
        .d_a (dr_reg[2]),
        .d_b (dr_reg[0]),
        .e_a (ext[2]),
        .e_b (ext[0]),
        .sep (cross_sep[1])
    );

    sobb_cross_axis u_cross_z (
        .clk (clk),
        .en  (cross_en),
        .m_a (mr_reg[0]),
        .m_b (mr_reg[1]),
        .d_a (dr_reg[0]),
        .d_b (dr_reg[1]),
        .e_a (ext[0]),
        .e_b (ext[1]),
        .sep (cross_sep[2])
    );

    // Output stage
    assign out_valid = v_reg[PIPE_DEPTH];
    assign hit       = !(face7_reg || (|cross_sep));

    // Checks
    a_empty_out_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with an empty output stage");

    a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
        ((&v_reg) && !out_ready) |-> !in_ready)
        else $error("input taken while every stage is full and stalled");

    a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> v_reg[1])
        else $error("accepted item missing from first stage");

endmodule

@@ verif/sobb_overlap_checker.sv @@
// Checker for the segment/box overlap test: tracks box registers, predicts hit, compares.
module sobb_overlap_checker (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    input  logic                                in_ready,
    input  logic signed [sobb_pkg::COORD_W-1:0] start_x,
    input  logic signed [sobb_pkg::COORD_W-1:0] start_y,
    input  logic signed [sobb_pkg::COORD_W-1:0] start_z,
    input  logic signed [sobb_pkg::COORD_W-1:0] end_x,
    input  logic signed [sobb_pkg::COORD_W-1:0] end_y,
    input  logic signed [sobb_pkg::COORD_W-1:0] end_z,
    input  logic                                out_valid,
    input  logic                                out_ready,
    input  logic                                hit,
    input  logic                                cfg_wr_en,
    input  logic [sobb_pkg::IDX_W-1:0]          cfg_index,
    input  logic [sobb_pkg::CFG_W-1:0]          cfg_data,
    output int                                  pending_hits,
    output int                                  fail_count
);
    import sobb_pkg::*;

    // Wide enough for every exact product in the cross-axis tests
    typedef logic signed [127:0] wide_t;

    // Shadow copy of the box registers
    logic [CFG_W-1:0]    center_q;
    logic [CFG_W-1:0]    extent_q;
    logic [3*AXIS_W-1:0] axis_q [3];

    bit hit_expected_q [$];
    int mismatches;

    function automatic wide_t magnitude(input wide_t v);
        return (v < 0) ? -v : v;
    endfunction

    // Cross axis built from two box axes: |m1*d2 - m2*d1| > e1*|d2| + e2*|d1|
    function automatic bit edge_axis_separates(input wide_t m1, input wide_t m2,
                                               input wide_t d1, input wide_t d2,
                                               input wide_t e1, input wide_t e2);
        return magnitude(m1 * d2 - m2 * d1) > e1 * magnitude(d2) + e2 * magnitude(d1);
    endfunction

    // Exact separating-axis test of one segment against the current box
    function automatic bit segment_hits(input logic signed [COORD_W-1:0] sx,
                                        input logic signed [COORD_W-1:0] sy,
                                        input logic signed [COORD_W-1:0] sz,
                                        input logic signed [COORD_W-1:0] ex,
                                        input logic signed [COORD_W-1:0] ey,
                                        input logic signed [COORD_W-1:0] ez);
        logic signed [COORD_W-1:0] s_pt [3];
        logic signed [COORD_W-1:0] e_pt [3];
        logic signed [COORD_W-1:0] ctr;
        logic signed [AXIS_W-1:0]  comp;
        wide_t mid2 [3];
        wide_t dir2 [3];
        wide_t ext [3];
        wide_t mrot [3];
        wide_t drot [3];
        s_pt[0] = sx;
        s_pt[1] = sy;
        s_pt[2] = sz;
        e_pt[0] = ex;
        e_pt[1] = ey;
        e_pt[2] = ez;
        // doubled midpoint relative to center, doubled half-vector, scaled extents
        for (int i = 0; i < 3; i++)
        begin
            ctr     = center_q[COORD_W*i +: COORD_W];
            mid2[i] = wide_t'(s_pt[i]) + wide_t'(e_pt[i]) - 2 * wide_t'(ctr);
            dir2[i] = wide_t'(e_pt[i]) - wide_t'(s_pt[i]);
            ext[i]  = wide_t'(extent_q[COORD_W*i +: COORD_W]) << EXT_SH;
        end
        // rotate into box space; rows used as given
        for (int r = 0; r < 3; r++)
        begin
            mrot[r] = '0;
            drot[r] = '0;
            for (int k = 0; k < 3; k++)
            begin
                comp    = axis_q[r][AXIS_W*k +: AXIS_W];
                mrot[r] = mrot[r] + wide_t'(comp) * mid2[k];
                drot[r] = drot[r] + wide_t'(comp) * dir2[k];
            end
        end
        // face axes
        for (int r = 0; r < 3; r++)
        begin
            if (magnitude(mrot[r]) > ext[r] + magnitude(drot[r]))
                return 1'b0;
        end
        // edge cross axes
        return !(edge_axis_separates(mrot[1], mrot[2], drot[1], drot[2], ext[1], ext[2]) ||
                 edge_axis_separates(mrot[2], mrot[0], drot[2], drot[0], ext[2], ext[0]) ||
                 edge_axis_separates(mrot[0], mrot[1], drot[0], drot[1], ext[0], ext[1]));
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_q  = '0;
            extent_q  = '0;
            axis_q[0] = AXIS_ROW0_RST;
            axis_q[1] = AXIS_ROW1_RST;
            axis_q[2] = AXIS_ROW2_RST;
            hit_expected_q.delete();
            mismatches = 0;
        end
        else
        begin
            // result side: compare against the oldest prediction
            if (out_valid && out_ready)
            begin
                if (hit_expected_q.size() == 0)
                begin
                    $display("%0t: unexpected result item, expected none, actual hit=%0b",
                             $time, hit);
                    mismatches++;
                end
                else
                begin
                    bit want;
                    want = hit_expected_q.pop_front();
                    if (hit !== want)
                    begin
                        $display("%0t: hit mismatch, expected %0b, actual %0b",
                                 $time, want, hit);
                        mismatches++;
                    end
                end
            end
            // segment side: predict with the registers in force now
            if (in_valid && in_ready)
                hit_expected_q.push_back(segment_hits(start_x, start_y, start_z,
                                                      end_x, end_y, end_z));
            // register writes; unused indexes fall through
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    REG_CENTER: center_q  = cfg_data;
                    REG_EXTENT: extent_q  = cfg_data;
                    REG_AXIS0:  axis_q[0] = cfg_data[3*AXIS_W-1:0];
                    REG_AXIS1:  axis_q[1] = cfg_data[3*AXIS_W-1:0];
                    REG_AXIS2:  axis_q[2] = cfg_data[3*AXIS_W-1:0];
                    default: ;
                endcase
            end
        end
        pending_hits <= hit_expected_q.size();
        fail_count   <= mismatches;
    end

endmodule

@@ verif/tb_segment_obb_overlap_test.sv @@
// Testbench top for the segment/box overlap test: clock, reset, stimulus and verdict.
module tb_segment_obb_overlap_test;
    import sobb_pkg::*;

    localparam int NUM_REGS        = REG_AXIS2 + 1;
    localparam int NUM_PHASES      = 8;
    localparam int ITEMS_PER_PHASE = 141;
    localparam int COORD_MAX       = (1 << (COORD_W - 1)) - 1;
    localparam int COORD_MIN       = -(1 << (COORD_W - 1));
    localparam int EXTENT_MAX      = (1 << COORD_W) - 1;
    localparam int AXIS_ONE        = 1 << AXIS_FRAC;
    localparam int AXIS_MAX        = (1 << (AXIS_W - 1)) - 1;
    localparam int AXIS_MIN        = -(1 << (AXIS_W - 1));
    localparam int COS45           = 11585;
    localparam int IDLE_PCT        = 30;

    // Directed box: center (10, 20, -30), half extents (4, 2, 1) in Q12.8
    localparam int BX = 2560;
    localparam int BY = 5120;
    localparam int BZ = -7680;
    localparam int HA = 1024;
    localparam int HB = 512;
    localparam int HC = 256;

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      in_valid = 1'b0;
    logic                      in_ready;
    logic signed [COORD_W-1:0] start_x = '0;
    logic signed [COORD_W-1:0] start_y = '0;
    logic signed [COORD_W-1:0] start_z = '0;
    logic signed [COORD_W-1:0] end_x = '0;
    logic signed [COORD_W-1:0] end_y = '0;
    logic signed [COORD_W-1:0] end_z = '0;
    logic                      out_valid;
    logic                      out_ready = 1'b0;
    logic                      hit;
    logic                      cfg_wr_en = 1'b0;
    logic [IDX_W-1:0]          cfg_index = '0;
    logic [CFG_W-1:0]          cfg_data = '0;

    int pending_hits;
    int fail_count;
    bit calm = 1'b0;

    // Box settings for the current phase and the region around it
    logic [CFG_W-1:0] box_cfg [NUM_REGS];
    int               box_ctr [3];
    int               span;

    segment_obb_overlap_test u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .start_x   (start_x),
        .start_y   (start_y),
        .start_z   (start_z),
        .end_x     (end_x),
        .end_y     (end_y),
        .end_z     (end_z),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .hit       (hit),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    sobb_overlap_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .start_x      (start_x),
        .start_y      (start_y),
        .start_z      (start_z),
        .end_x        (end_x),
        .end_y        (end_y),
        .end_z        (end_z),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .hit          (hit),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .pending_hits (pending_hits),
        .fail_count   (fail_count)
    );

    always #5 clk = ~clk;

    // Result side stalls about 30% of cycles unless in a calm stretch
    always @(posedge clk)
        out_ready <= calm || ($urandom_range(99) >= IDLE_PCT);

    function automatic int rand_between(input int lo, input int hi);
        return lo + int'($urandom_range(hi - lo));
    endfunction

    function automatic logic [CFG_W-1:0] coord_triple(input int x, input int y, input int z);
        return {COORD_W'(z), COORD_W'(y), COORD_W'(x)};
    endfunction

    function automatic logic [CFG_W-1:0] axis_row(input int x, input int y, input int z);
        return CFG_W'({AXIS_W'(z), AXIS_W'(y), AXIS_W'(x)});
    endfunction

    // Coordinate near the box along one world axis, saturated to the field range
    function automatic int near_coord(input int axis);
        int v;
        v = box_ctr[axis] + rand_between(-span, span);
        if (v > COORD_MAX)
            v = COORD_MAX;
        if (v < COORD_MIN)
            v = COORD_MIN;
        return v;
    endfunction

    function automatic int pick_extreme();
        case ($urandom_range(4))
            0:       return COORD_MIN;
            1:       return COORD_MAX;
            2:       return 0;
            3:       return -1;
            default: return rand_between(COORD_MIN, COORD_MAX);
        endcase
    endfunction

    // Offer one segment item and hold it until accepted
    task automatic send_segment(input int sx, input int sy, input int sz,
                                input int ex, input int ey, input int ez);
        while (!calm && $urandom_range(99) < IDLE_PCT)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        start_x  <= COORD_W'(sx);
        start_y  <= COORD_W'(sy);
        start_z  <= COORD_W'(sz);
        end_x    <= COORD_W'(ex);
        end_y    <= COORD_W'(ey);
        end_z    <= COORD_W'(ez);
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    // Drop valid and let the pipeline empty before touching registers
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_hits != 0)
            @(posedge clk);
        repeat (PIPE_DEPTH + 4) @(posedge clk);
    endtask

    // Write all five box registers back to back, optionally hitting unused indexes
    task automatic program_box(input bit add_unused);
        for (int idx = REG_CENTER; idx <= REG_AXIS2; idx++)
        begin
            cfg_wr_en <= 1'b1;
            cfg_index <= IDX_W'(idx);
            cfg_data  <= box_cfg[idx];
            @(posedge clk);
        end
        if (add_unused)
        begin
            for (int idx = REG_AXIS2 + 1; idx < (1 << IDX_W); idx++)
            begin
                cfg_wr_en <= 1'b1;
                cfg_index <= IDX_W'(idx);
                cfg_data  <= CFG_W'({$urandom(), $urandom()});
                @(posedge clk);
            end
        end
        cfg_wr_en <= 1'b0;
    endtask

    // Run limit
    initial
    begin
        #4000000;
        $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        int  kind;
        int  ext_big;
        bit  junk;
        int  pa [3];
        int  pb [3];

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset box: zero extents at the origin, only the center point touches it
        send_segment(0, 0, 0, 0, 0, 0);
        send_segment(-256, 0, 0, 256, 0, 0);
        send_segment(1, 0, 0, 1, 0, 0);
        settle();

        // axis-aligned box for the directed cases
        box_cfg[REG_CENTER] = coord_triple(BX, BY, BZ);
        box_cfg[REG_EXTENT] = coord_triple(HA, HB, HC);
        box_cfg[REG_AXIS0]  = axis_row(AXIS_ONE, 0, 0);
        box_cfg[REG_AXIS1]  = axis_row(0, AXIS_ONE, 0);
        box_cfg[REG_AXIS2]  = axis_row(0, 0, AXIS_ONE);
        program_box(1'b0);

        // points: center, on a face, just past a face
        send_segment(BX, BY, BZ, BX, BY, BZ);
        send_segment(BX + HA, BY, BZ, BX + HA, BY, BZ);
        send_segment(BX + HA + 1, BY, BZ, BX + HA + 1, BY, BZ);
        send_segment(BX, BY, BZ - HC - 1, BX, BY, BZ - HC - 1);
        // straight through, parallel outside, ending on a face
        send_segment(BX - 3000, BY, BZ, BX + 3000, BY, BZ);
        send_segment(BX - 3000, BY + HB + 10, BZ, BX + 3000, BY + HB + 10, BZ);
        send_segment(BX + HA + 500, BY, BZ, BX + HA, BY, BZ);
        // passing a corner: face tests pass, an edge cross axis separates
        send_segment(BX + HA + 400, BY + HB - 300, BZ, BX + HA - 300, BY + HB + 400, BZ);
        send_segment(BX, BY + HB + 300, BZ + HC - 200, BX, BY + HB - 200, BZ + HC + 300);
        send_segment(BX + HA + 300, BY, BZ + HC - 200, BX + HA - 200, BY, BZ + HC + 300);
        // grazing the corner exactly counts as contact
        send_segment(BX + HA + 350, BY + HB - 350, BZ, BX + HA - 350, BY + HB + 350, BZ);
        // coordinate extremes
        send_segment(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN);
        send_segment(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX);
        send_segment(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MAX);
        send_segment(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN, COORD_MIN);
        send_segment(COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX);
        send_segment(0, 0, 0, -1, -1, -1);

        // random phases, each under its own box
        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            settle();
            box_cfg[REG_CENTER] = coord_triple(rand_between(-20000, 20000),
                                               rand_between(-20000, 20000),
                                               rand_between(-20000, 20000));
            box_cfg[REG_EXTENT] = coord_triple(rand_between(256, 8192),
                                               rand_between(256, 8192),
                                               rand_between(256, 8192));
            junk = 1'b0;
            case (ph)
                0:
                begin
                    box_cfg[REG_AXIS0] = axis_row(AXIS_ONE, 0, 0);
                    box_cfg[REG_AXIS1] = axis_row(0, AXIS_ONE, 0);
                    box_cfg[REG_AXIS2] = axis_row(0, 0, AXIS_ONE);
                end
                1:
                begin
                    // rotated 45 degrees about z
                    box_cfg[REG_AXIS0] = axis_row(COS45, -COS45, 0);
                    box_cfg[REG_AXIS1] = axis_row(COS45, COS45, 0);
                    box_cfg[REG_AXIS2] = axis_row(0, 0, AXIS_ONE);
                end
                2:
                begin
                    // permuted and negated axes
                    box_cfg[REG_AXIS0] = axis_row(0, AXIS_ONE, 0);
                    box_cfg[REG_AXIS1] = axis_row(0, 0, -AXIS_ONE);
                    box_cfg[REG_AXIS2] = axis_row(-AXIS_ONE, 0, 0);
                end
                3:
                begin
                    box_cfg[REG_CENTER] = coord_triple(COORD_MAX, COORD_MAX, COORD_MAX);
                    box_cfg[REG_EXTENT] = coord_triple(EXTENT_MAX, EXTENT_MAX, EXTENT_MAX);
                    box_cfg[REG_AXIS0]  = axis_row(AXIS_MAX, AXIS_MAX, AXIS_MAX);
                    box_cfg[REG_AXIS1]  = axis_row(AXIS_MAX, AXIS_MAX, AXIS_MAX);
                    box_cfg[REG_AXIS2]  = axis_row(AXIS_MAX, AXIS_MAX, AXIS_MAX);
                end
                4:
                begin
                    box_cfg[REG_CENTER] = coord_triple(COORD_MIN, COORD_MIN, COORD_MIN);
                    box_cfg[REG_EXTENT] = '0;
                    box_cfg[REG_AXIS0]  = axis_row(AXIS_MIN, AXIS_MIN, AXIS_MIN);
                    box_cfg[REG_AXIS1]  = axis_row(AXIS_MIN, AXIS_MIN, AXIS_MIN);
                    box_cfg[REG_AXIS2]  = axis_row(AXIS_MIN, AXIS_MIN, AXIS_MIN);
                end
                7:
                begin
                    // skewed axes, not orthonormal
                    box_cfg[REG_AXIS0] = axis_row(AXIS_ONE + rand_between(-3000, 3000),
                                                  rand_between(-2000, 2000),
                                                  rand_between(-2000, 2000));
                    box_cfg[REG_AXIS1] = axis_row(rand_between(-2000, 2000),
                                                  AXIS_ONE + rand_between(-3000, 3000),
                                                  rand_between(-2000, 2000));
                    box_cfg[REG_AXIS2] = axis_row(rand_between(-2000, 2000),
                                                  rand_between(-2000, 2000),
                                                  AXIS_ONE + rand_between(-3000, 3000));
                end
                default:
                begin
                    // every register bit random, stray bits included
                    for (int r = REG_CENTER; r <= REG_AXIS2; r++)
                        box_cfg[r] = CFG_W'({$urandom(), $urandom()});
                    junk = 1'b1;
                end
            endcase
            program_box(junk);

            // sampling region around the box
            ext_big = 0;
            for (int i = 0; i < 3; i++)
            begin
                box_ctr[i] = int'($signed(box_cfg[REG_CENTER][COORD_W*i +: COORD_W]));
                if (int'(box_cfg[REG_EXTENT][COORD_W*i +: COORD_W]) > ext_big)
                    ext_big = int'(box_cfg[REG_EXTENT][COORD_W*i +: COORD_W]);
            end
            span = 2 * ext_big + 256;

            calm = (ph == 0);
            repeat (ITEMS_PER_PHASE)
            begin
                kind = $urandom_range(99);
                for (int i = 0; i < 3; i++)
                begin
                    pa[i] = near_coord(i);
                    pb[i] = near_coord(i);
                end
                if (kind < 55)
                    ;
                else if (kind < 70)
                begin
                    // long segment from near the box out to anywhere
                    for (int i = 0; i < 3; i++)
                        pb[i] = rand_between(COORD_MIN, COORD_MAX);
                end
                else if (kind < 80)
                    pb = pa;
                else if (kind < 92)
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        pa[i] = rand_between(COORD_MIN, COORD_MAX);
                        pb[i] = rand_between(COORD_MIN, COORD_MAX);
                    end
                end
                else
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        pa[i] = pick_extreme();
                        pb[i] = pick_extreme();
                    end
                end
                send_segment(pa[0], pa[1], pa[2], pb[0], pb[1], pb[2]);
            end
            calm = 1'b0;
        end

        // drain and verdict
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_hits != 0)
            @(posedge clk);
        repeat (PIPE_DEPTH + 6) @(posedge clk);
        if (fail_count == 0 && pending_hits == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
